// ===== src/drop_oldest_ring_queue_unit_assert.svh =====
// Assertion macros shared by the ring queue RTL.
// Define ASSERT_OFF to compile them out; no other dependencies.
`ifndef DROP_OLDEST_RING_QUEUE_UNIT_ASSERT_SVH
`define DROP_OLDEST_RING_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define DOQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("doq assertion failed");

// Expression must never be true at a clock edge outside reset.
`define DOQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("doq assertion failed");

`else

`define DOQ_ASSERT(lbl, clk, rst_n, prop)
`define DOQ_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== src/doq_pkg.sv =====
// Package for the drop-oldest ring queue: item kinds, result bundle and
// default sizes. No dependencies.
package doq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned DataWidthDefault  = 64;

  localparam int unsigned DataBusW  = 64;
  localparam int unsigned CountOutW = 5;
  localparam int unsigned DropW     = 32;

  typedef enum logic {
    KindPush = 1'b0,
    KindPop  = 1'b1
  } kind_e;

  typedef struct packed {
    logic                 read_valid;
    logic                 overwrote;
    logic [CountOutW-1:0] occupancy;
    logic [CountOutW-1:0] high_water;
    logic [DropW-1:0]     drop_total;
  } res_t;

endpackage

// ===== src/drop_oldest_ring_queue_unit.sv =====
// Drop-oldest ring queue: a FIFO that never refuses a push.
// Depends on doq_pkg and drop_oldest_ring_queue_unit_assert.svh.
//
// One push or pop is accepted per cycle while in_ready_o is high. Its result is
// registered into the output register, or into the skid register while the
// output register holds a result not yet taken. Pointer and count updates are
// single increments; the store has one write and one registered read port.
// A two-slot result buffer (output plus skid register) takes a new item while
// a result waits; in_ready_o drops only when both slots are full. A push into a
// full queue overwrites the oldest entry and counts a drop (saturating). A pop
// on an empty queue returns read_valid low and changes nothing. Entries are
// read only after being written, so the store needs no clearing after reset.
module drop_oldest_ring_queue_unit #(
  parameter int unsigned QueueDepth = doq_pkg::QueueDepthDefault,
  parameter int unsigned DataWidth  = doq_pkg::DataWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [doq_pkg::DataBusW-1:0]  write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          read_valid_o,
  output logic [doq_pkg::DataBusW-1:0]  read_data_o,
  output logic                          overwrote_oldest_o,
  output logic [doq_pkg::CountOutW-1:0] occupancy_o,
  output logic [doq_pkg::CountOutW-1:0] high_water_o,
  output logic [doq_pkg::DropW-1:0]     drop_total_o
);

  `include "drop_oldest_ring_queue_unit_assert.svh"

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);
  localparam logic [doq_pkg::DropW-1:0] DropMax = '1;

  logic [DataWidth-1:0] mem_q [QueueDepth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] peak_q, peak_d;
  logic [doq_pkg::DropW-1:0] drop_q, drop_d;

  logic out_vld_q, out_vld_d;
  logic skid_vld_q, skid_vld_d;
  doq_pkg::res_t out_res_q, out_res_d;
  doq_pkg::res_t skid_res_q, skid_res_d;
  logic [DataWidth-1:0] out_data_q;
  logic [DataWidth-1:0] skid_data_q;

  doq_pkg::kind_e kind;
  doq_pkg::res_t  res;
  logic accept, out_take, out_free, load_out_new, load_skid, skid_to_out;
  logic is_push, pop_hit, full;

  assign kind       = doq_pkg::kind_e'(kind_i);
  assign in_ready_o = !skid_vld_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_take   = out_vld_q && out_ready_i;
  assign out_free   = !out_vld_q || out_take;
  assign skid_to_out  = skid_vld_q && out_free;
  assign load_out_new = accept && out_free;
  assign load_skid    = accept && !out_free;

  assign is_push = (kind == doq_pkg::KindPush);
  assign full    = (cnt_q == CntFull);
  assign pop_hit = !is_push && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    peak_d   = peak_q;
    drop_d   = drop_q;
    res      = '0;
    if (is_push) begin
      if (full) begin
        res.overwrote = 1'b1;
        if (drop_q != DropMax) begin
          drop_d = drop_q + 1'b1;
        end
        rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      if (cnt_d > peak_q) begin
        peak_d = cnt_d;
      end
    end else if (pop_hit) begin
      res.read_valid = 1'b1;
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      cnt_d    = cnt_q - 1'b1;
    end
    res.occupancy  = doq_pkg::CountOutW'(cnt_d);
    res.high_water = doq_pkg::CountOutW'(peak_d);
    res.drop_total = drop_d;
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_res_d  = out_res_q;
    skid_res_d = skid_res_q;
    if (out_free) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_res_d  = skid_res_q;
        skid_vld_d = 1'b0;
      end else if (accept) begin
        out_vld_d = 1'b1;
        out_res_d = res;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (accept) begin
      skid_vld_d = 1'b1;
      skid_res_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
      peak_q     <= '0;
      drop_q     <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        wr_ptr_q <= wr_ptr_d;
        rd_ptr_q <= rd_ptr_d;
        cnt_q    <= cnt_d;
        peak_q   <= peak_d;
        drop_q   <= drop_d;
      end
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  // Entry store: one write port, one registered read port feeding both slots.
  always_ff @(posedge clk_i) begin
    if (accept && is_push) begin
      mem_q[wr_ptr_q] <= write_data_i[DataWidth-1:0];
    end
    if (skid_to_out) begin
      out_data_q <= skid_data_q;
    end else if (load_out_new && pop_hit) begin
      out_data_q <= mem_q[rd_ptr_q];
    end
    if (load_skid && pop_hit) begin
      skid_data_q <= mem_q[rd_ptr_q];
    end
  end

  assign out_valid_o        = out_vld_q;
  assign read_valid_o       = out_res_q.read_valid;
  assign read_data_o        = out_res_q.read_valid ? doq_pkg::DataBusW'(out_data_q) : '0;
  assign overwrote_oldest_o = out_res_q.overwrote;
  assign occupancy_o        = out_res_q.occupancy;
  assign high_water_o       = out_res_q.high_water;
  assign drop_total_o       = out_res_q.drop_total;

  `DOQ_ASSERT_NEVER(cnt_over_depth_a, clk_i, rst_ni, cnt_q > CntFull)
  `DOQ_ASSERT_NEVER(skid_without_out_a, clk_i, rst_ni, skid_vld_q && !out_vld_q)
  `DOQ_ASSERT(ptr_meet_a, clk_i, rst_ni,
    (cnt_q == '0 || cnt_q == CntFull) |-> (rd_ptr_q == wr_ptr_q))
  `DOQ_ASSERT(peak_covers_cnt_a, clk_i, rst_ni, peak_q >= cnt_q)
  `DOQ_ASSERT(drop_monotonic_a, clk_i, rst_ni, 1'b1 |=> (drop_q >= $past(drop_q)))

endmodule
